@@ hdl/nrfe_pkg.sv @@
// Package for the NMEA RMC field extractor.
// Holds the result type, character and code constants and the header lookup.
// Depends on nothing; used by every other file of the block.
`default_nettype none

package nrfe_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_E      = 8'h45;
    localparam logic [7:0] CHAR_W      = 8'h57;

    localparam int HEADER_LEN = 6;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic SEL_LAT  = 1'b0;
    localparam logic SEL_LONG = 1'b1;

    localparam logic [1:0] FIELD_NONE = 2'd0;
    localparam logic [1:0] FIELD_LAT  = 2'd1;
    localparam logic [1:0] FIELD_LONG = 2'd2;

    localparam logic [1:0] CFG_LAT_COMMAS  = 2'd0;
    localparam logic [1:0] CFG_LONG_COMMAS = 2'd1;

    typedef struct packed {
        logic       kind;
        logic       field_select;
        logic [7:0] char_value;
        logic [6:0] char_index;
        logic       header_is_rmc;
        logic [7:0] fix_status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    char_push;
        result_t char_res;
        logic    sum_push;
        result_t sum_res;
    } push_t;

    // Expected byte of the "$GPRMC" header at a given sentence position.
    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h24;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/nrfe_core.sv @@
// Sentence tracker: per-byte state update and result generation.
// Uses nrfe_pkg; feeds its results to nrfe_fifo.
`default_nettype none

module nrfe_core #(
    parameter int MAX_LEN = 128
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  byte_fire,
    input  wire [7:0]            in_byte,
    input  wire [6:0]            lat_commas,
    input  wire [6:0]            long_commas,
    output nrfe_pkg::push_t      push
);
    import nrfe_pkg::*;

    logic       hunting_reg, hunting_next;
    logic [7:0] position_reg, position_next;
    logic [7:0] comma_reg, comma_next;
    logic       header_reg, header_next;
    logic [7:0] status_reg, status_next;
    logic       pending_reg, pending_next;
    logic [1:0] active_reg, active_next;
    logic [6:0] fpos_reg, fpos_next;

    logic       char_emit;
    logic       sum_emit;
    logic       sum_header;
    logic [7:0] sum_status;

    always_comb
    begin
        hunting_next  = hunting_reg;
        position_next = position_reg;
        comma_next    = comma_reg;
        header_next   = header_reg;
        status_next   = status_reg;
        pending_next  = pending_reg;
        active_next   = active_reg;
        fpos_next     = fpos_reg;
        char_emit     = 1'b0;
        sum_emit      = 1'b0;
        sum_header    = 1'b0;
        sum_status    = 8'd0;

        if (hunting_reg)
        begin
            if (in_byte == CHAR_DOLLAR)
            begin
                hunting_next  = 1'b0;
                position_next = 8'd1;
                comma_next    = 8'd0;
                header_next   = 1'b1;
                status_next   = 8'd0;
                pending_next  = 1'b0;
                active_next   = FIELD_NONE;
                fpos_next     = 7'd0;
            end
        end
        else if (in_byte inside {CHAR_E, CHAR_W})
        begin
            sum_emit   = 1'b1;
            sum_header = header_reg && (position_reg >= 8'(HEADER_LEN));
            sum_status = status_reg;
        end
        else
        begin
            if (position_reg < 8'(HEADER_LEN) && in_byte != header_char(position_reg[2:0]))
            begin
                header_next = 1'b0;
            end
            if (pending_reg)
            begin
                status_next  = in_byte;
                pending_next = 1'b0;
            end
            if (in_byte == CHAR_COMMA)
            begin
                active_next = FIELD_NONE;
                if (comma_reg != 8'hFF)
                begin
                    comma_next = comma_reg + 8'd1;
                end
                if (comma_next == 8'd2)
                begin
                    pending_next = 1'b1;
                end
                if (lat_commas != 7'd0 && comma_next == {1'b0, lat_commas})
                begin
                    active_next = FIELD_LAT;
                    fpos_next   = 7'd0;
                end
                else if (long_commas != 7'd0 && comma_next == {1'b0, long_commas})
                begin
                    active_next = FIELD_LONG;
                    fpos_next   = 7'd0;
                end
            end
            else if (active_reg != FIELD_NONE)
            begin
                char_emit = 1'b1;
                if (fpos_reg != 7'h7F)
                begin
                    fpos_next = fpos_reg + 7'd1;
                end
            end
            if (position_reg != 8'hFF)
            begin
                position_next = position_reg + 8'd1;
            end
            if (position_next >= 8'(MAX_LEN))
            begin
                sum_emit   = 1'b1;
                sum_header = header_next && (position_next >= 8'(HEADER_LEN));
                sum_status = status_next;
            end
        end

        if (sum_emit)
        begin
            hunting_next  = 1'b1;
            position_next = 8'd0;
            comma_next    = 8'd0;
            header_next   = 1'b1;
            status_next   = 8'd0;
            pending_next  = 1'b0;
            active_next   = FIELD_NONE;
            fpos_next     = 7'd0;
        end
    end

    always_comb
    begin
        push.char_push              = byte_fire && char_emit;
        push.char_res.kind          = KIND_CHAR;
        push.char_res.field_select  = (active_reg == FIELD_LONG) ? SEL_LONG : SEL_LAT;
        push.char_res.char_value    = in_byte;
        push.char_res.char_index    = fpos_reg;
        push.char_res.header_is_rmc = 1'b0;
        push.char_res.fix_status    = 8'd0;
        push.char_res.last          = !sum_emit;

        push.sum_push              = byte_fire && sum_emit;
        push.sum_res.kind          = KIND_SUMMARY;
        push.sum_res.field_select  = SEL_LAT;
        push.sum_res.char_value    = 8'd0;
        push.sum_res.char_index    = 7'd0;
        push.sum_res.header_is_rmc = sum_header;
        push.sum_res.fix_status    = sum_status;
        push.sum_res.last          = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg  <= 1'b1;
            position_reg <= 8'd0;
            comma_reg    <= 8'd0;
            header_reg   <= 1'b1;
            status_reg   <= 8'd0;
            pending_reg  <= 1'b0;
            active_reg   <= FIELD_NONE;
            fpos_reg     <= 7'd0;
        end
        else if (byte_fire)
        begin
            hunting_reg  <= hunting_next;
            position_reg <= position_next;
            comma_reg    <= comma_next;
            header_reg   <= header_next;
            status_reg   <= status_next;
            pending_reg  <= pending_next;
            active_reg   <= active_next;
            fpos_reg     <= fpos_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nrfe_fifo.sv @@
// Result queue of four entries that takes up to two results per cycle.
// Uses nrfe_pkg; decouples the tracker from the output handshake.
`default_nettype none

module nrfe_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire nrfe_pkg::push_t push,
    output logic                 space_ok,
    output logic                 pop_valid,
    input  wire                  pop_ready,
    output nrfe_pkg::result_t    head
);
    import nrfe_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    result_t         entry_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic [AW-1:0]   sum_addr;
    logic            pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign space_ok  = count_reg <= (AW + 1)'(DEPTH - 2);
    assign sum_addr  = wr_ptr_reg + AW'(push.char_push);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.char_push) + AW'(push.sum_push);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW + 1)'(push.char_push) + (AW + 1)'(push.sum_push)
                      - (AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.char_push)
        begin
            entry_reg[wr_ptr_reg] <= push.char_res;
        end
        if (push.sum_push)
        begin
            entry_reg[sum_addr] <= push.sum_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/nmea_rmc_field_extractor.sv @@
// Top level of the NMEA RMC field extractor.
// Instantiates nrfe_core and nrfe_fifo and holds the two comma-count registers; uses nrfe_pkg.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_ready    in_byte
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//  result    out_valid / out_ready  kind, field_select, char_value, char_index,
//                                   header_is_rmc, fix_status, last
//
// One byte is taken per cycle while in_ready is high; its results enter the queue at the
// accepting edge and are offered once the results ahead of them have left.
// A byte that fills the length limit and also gives a field character yields two
// results, character then summary, which leave in that order through the four-entry result queue.
// in_ready falls while fewer than two queue entries are free; cfg_ready is always high.
// Reset puts the tracker in the hunting state and loads comma counts 3 and 5.
`default_nettype none

module nmea_rmc_field_extractor #(
    parameter int MAX_LEN = 128
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire [7:0]  in_byte,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_index,
    input  wire [6:0]  cfg_data,
    output logic       out_valid,
    input  wire        out_ready,
    output logic       kind,
    output logic       field_select,
    output logic [7:0] char_value,
    output logic [6:0] char_index,
    output logic       header_is_rmc,
    output logic [7:0] fix_status,
    output logic       last
);
    import nrfe_pkg::*;

    logic [6:0] lat_commas_reg;
    logic [6:0] long_commas_reg;
    logic       byte_fire;
    logic       space_ok;
    push_t      push;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign in_ready  = space_ok;
    assign byte_fire = in_valid && space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_commas_reg  <= 7'd3;
            long_commas_reg <= 7'd5;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LAT_COMMAS:  lat_commas_reg  <= cfg_data;
                CFG_LONG_COMMAS: long_commas_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    nrfe_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (byte_fire),
        .in_byte     (in_byte),
        .lat_commas  (lat_commas_reg),
        .long_commas (long_commas_reg),
        .push        (push)
    );

    nrfe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .head      (head)
    );

    assign kind          = head.kind;
    assign field_select  = head.field_select;
    assign char_value    = head.char_value;
    assign char_index    = head.char_index;
    assign header_is_rmc = head.header_is_rmc;
    assign fix_status    = head.fix_status;
    assign last          = head.last;

endmodule

`default_nettype wire
